[rtl/dgpe_pkg.sv]
// Shared types, constants and gradient arithmetic for the dual-gradient pixel energy unit.
package dgpe_pkg;

    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int SQ_W     = 2 * CH_W;
    localparam int GRAD_W   = 18;
    localparam int ENERGY_W = 19;
    localparam int COORD_W  = 10;
    localparam int CFG_W    = 11;

    // Image size after reset, before saturation to the configured maximum
    localparam int CFG_RESET_SIZE = 1024;

    typedef logic [PIX_W-1:0]    pixel_t;
    typedef logic [GRAD_W-1:0]   grad_t;
    typedef logic [ENERGY_W-1:0] energy_t;
    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [CFG_W-1:0]    cfg_data_t;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Squared absolute difference of one 8-bit channel
    function automatic logic [SQ_W-1:0] chan_sq(logic [CH_W-1:0] x, logic [CH_W-1:0] y);
        logic [CH_W-1:0] d;
        logic [SQ_W-1:0] dw;
        d  = (x > y) ? (x - y) : (y - x);
        dw = {{CH_W{1'b0}}, d};
        return dw * dw;
    endfunction

    // Sum of squared differences over red, green and blue
    function automatic grad_t grad_sq(pixel_t a, pixel_t b);
        grad_t s;
        s = GRAD_W'(chan_sq(a[23:16], b[23:16]))
          + GRAD_W'(chan_sq(a[15:8],  b[15:8]))
          + GRAD_W'(chan_sq(a[7:0],   b[7:0]));
        return s;
    endfunction

endpackage

[rtl/dgpe_if.sv]
// Valid/ready stream interfaces for pixel input beats and energy result beats.
interface dgpe_pixel_if;
    import dgpe_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel_rgb;

    modport source (output valid, output pixel_rgb, input ready);
    modport sink   (input valid, input pixel_rgb, output ready);
endinterface

interface dgpe_energy_if;
    import dgpe_pkg::*;

    logic    valid;
    logic    ready;
    energy_t energy;
    coord_t  out_row;
    coord_t  out_col;
    logic    last_of_image;

    modport source (output valid, output energy, output out_row, output out_col,
                    output last_of_image, input ready);
    modport sink   (input valid, input energy, input out_row, input out_col,
                    input last_of_image, output ready);
endinterface

[rtl/dual_gradient_pixel_energy_unit.sv]
// Top level of the dual-gradient pixel energy unit: counters, window, pipeline and output.
//
// Usage
//   pixel_in   : RGB pixels in raster order, one beat per pixel (red 23:16, green 15:8,
//                blue 7:0). Width and height come from cfg_we/cfg_index/cfg_data and are
//                saturated to [2, MAX_WIDTH] and [2, MAX_HEIGHT]; write them while idle.
//   energy_out : one beat per energy, tagged with row, column and last_of_image.
//   Energies lag about one row: the pixel at (r, c) releases the energy of (r-1, c).
//   On the last row each pixel past column 0 also releases (r, c-1), and the last pixel (r, c).
//   An energy passes the stage 1 operand registers, the result group and the output register.
//   Throughput: one pixel per cycle on rows 0..H-2 while energy_out is ready. The last row
//   releases two energies per pixel (one at column 0, three at its end), so there the rate
//   is set by the one-beat-per-cycle output register.
//   Line memories hold rows r-1 and r-2; each is read once per pixel, one column ahead,
//   so the read of column c+1 lands while column c is being computed.
//   Reset: counters to row 0, column 0, sizes to 1024 (saturated), window cleared.
//   The line memories are not cleared; every row is rewritten before it is read.
//   Output stall: results wait in the output register, the result group stage and the
//   stage 1 operand registers; pixel_in.ready drops once all three are held, and on the
//   last row also while a result group with more than one energy drains.
module dual_gradient_pixel_energy_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  dgpe_pkg::cfg_index_t    cfg_index,
    input  dgpe_pkg::cfg_data_t     cfg_data,
    dgpe_pixel_if.sink              pixel_in,
    dgpe_energy_if.source           energy_out
);
    import dgpe_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    // Which results a pixel releases
    typedef struct packed {
        logic corner;   // last pixel of the image
        logic left;     // left neighbor on the last row
        logic above;    // pixel one row up
    } res_mask_t;

    function automatic logic [WID_W-1:0] clamp_width(cfg_data_t v);
        logic [WID_W-1:0] res;
        if (32'(v) < 32'd2)
            res = WID_W'(2);
        else if (32'(v) > 32'(MAX_WIDTH))
            res = WID_W'(MAX_WIDTH);
        else
            res = WID_W'(v);
        return res;
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(cfg_data_t v);
        logic [HGT_W-1:0] res;
        if (32'(v) < 32'd2)
            res = HGT_W'(2);
        else if (32'(v) > 32'(MAX_HEIGHT))
            res = HGT_W'(MAX_HEIGHT);
        else
            res = HGT_W'(v);
        return res;
    endfunction

    // ---------------- configuration ----------------
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= clamp_width(CFG_W'(CFG_RESET_SIZE));
            height_reg <= clamp_height(CFG_W'(CFG_RESET_SIZE));
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= clamp_width(cfg_data);
                REG_IMAGE_HEIGHT: height_reg <= clamp_height(cfg_data);
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // ---------------- position counters and window ----------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    pixel_t           win0_reg, win1_reg, win2_reg;   // above c-1, current c-1, current c-2

    logic             restart;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             c_zero, c_one, c_last, r_one, r_last;
    logic             in_ready, in_acc;
    pixel_t           pix;
    pixel_t           above_c, two_c;

    assign pix = pixel_in.pixel_rgb;

    // A size change can leave the counters out of range: start a new image then
    assign restart = (WID_W'(col_reg) >= width_reg) || (HGT_W'(row_reg) >= height_reg);
    assign cur_col = restart ? '0 : col_reg;
    assign cur_row = restart ? '0 : row_reg;

    assign c_zero = (cur_col == '0);
    assign c_one  = (cur_col == COL_W'(1));
    assign c_last = (WID_W'(cur_col) == (width_reg - 1'b1));
    assign r_one  = (cur_row == ROW_W'(1));
    assign r_last = (HGT_W'(cur_row) == (height_reg - 1'b1));

    always_comb
    begin
        col_next = cur_col + 1'b1;
        row_next = cur_row;
        if (c_last)
        begin
            col_next = '0;
            row_next = r_last ? '0 : (cur_row + 1'b1);
        end
    end

    assign in_acc = pixel_in.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            win0_reg <= '0;
            win1_reg <= '0;
            win2_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            win2_reg <= win1_reg;
            win1_reg <= pix;
            win0_reg <= above_c;
        end
    end

    // ---------------- line memories ----------------
    // Read one column ahead; write this column's new contents on the same edge.
    // Read and write addresses never match since the width is at least two.
    pixel_t rd_above;

    dgpe_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .clk      (clk),
        .rd_en    (in_acc),
        .rd_addr  (col_next),
        .rd_above (rd_above),
        .rd_two   (two_c),
        .wr_en    (in_acc),
        .wr_addr  (cur_col),
        .wr_above (pix),
        .wr_two   (above_c)
    );

    // Prefetched entries for the column now at the input
    assign above_c = rd_above;

    // ---------------- stage 1: operands, energy math ----------------
    logic             s1_valid_reg;
    pixel_t           s1_pix_reg, s1_above_reg, s1_ha1_reg, s1_va1_reg;
    pixel_t           s1_ha2_reg, s1_win0_reg, s1_win1_reg;
    logic             s1_c_last_reg;
    res_mask_t        s1_mask_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_adv;
    res_mask_t        acc_mask;
    pixel_t           hb1;
    energy_t          e1, e2, e3;

    assign acc_mask.above  = (cur_row != '0);
    assign acc_mask.left   = r_last && !c_zero;
    assign acc_mask.corner = r_last && c_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg    <= pix;
            s1_above_reg  <= above_c;
            s1_ha1_reg    <= c_zero ? above_c : win0_reg;
            s1_va1_reg    <= r_one ? above_c : two_c;
            s1_ha2_reg    <= c_one ? win1_reg : win2_reg;
            s1_win0_reg   <= win0_reg;
            s1_win1_reg   <= win1_reg;
            s1_c_last_reg <= c_last;
            s1_mask_reg   <= acc_mask;
            s1_col_reg    <= cur_col;
            s1_row_reg    <= cur_row;
        end
    end

    // rd_above now holds column c+1 of the row above; it holds while stage 1 waits
    assign hb1 = s1_c_last_reg ? s1_above_reg : rd_above;

    assign e1 = ENERGY_W'(grad_sq(s1_ha1_reg, hb1))
              + ENERGY_W'(grad_sq(s1_va1_reg, s1_pix_reg));
    assign e2 = ENERGY_W'(grad_sq(s1_ha2_reg, s1_pix_reg))
              + ENERGY_W'(grad_sq(s1_win1_reg, s1_win0_reg));
    assign e3 = ENERGY_W'(grad_sq(s1_pix_reg, s1_win1_reg))
              + ENERGY_W'(grad_sq(s1_pix_reg, s1_above_reg));

    // ---------------- stage 2: result group, drained one per beat ----------------
    res_mask_t        s2_mask_reg, s2_mask_next;
    energy_t          s2_e1_reg, s2_e2_reg, s2_e3_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic             out_valid_reg;
    energy_t          out_energy_reg, sel_energy;
    coord_t           out_row_reg, out_col_reg, sel_row, sel_col;
    logic             out_last_reg, sel_last;
    logic             out_load, s2_multi, s2_free;

    assign out_load = (s2_mask_reg != '0) && (!out_valid_reg || energy_out.ready);
    assign s2_multi = (s2_mask_reg.above && s2_mask_reg.left)
                   || (s2_mask_reg.above && s2_mask_reg.corner)
                   || (s2_mask_reg.left && s2_mask_reg.corner);
    assign s2_free  = (s2_mask_reg == '0) || (out_load && !s2_multi);
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s1_adv;

    // Results leave in order: row above, left neighbor, image corner
    always_comb
    begin
        s2_mask_next = s2_mask_reg;
        priority if (s2_mask_reg.above)
        begin
            sel_energy         = s2_e1_reg;
            sel_row            = COORD_W'(s2_row_reg - 1'b1);
            sel_col            = COORD_W'(s2_col_reg);
            sel_last           = 1'b0;
            s2_mask_next.above = 1'b0;
        end
        else if (s2_mask_reg.left)
        begin
            sel_energy        = s2_e2_reg;
            sel_row           = COORD_W'(s2_row_reg);
            sel_col           = COORD_W'(s2_col_reg - 1'b1);
            sel_last          = 1'b0;
            s2_mask_next.left = 1'b0;
        end
        else
        begin
            sel_energy          = s2_e3_reg;
            sel_row             = COORD_W'(s2_row_reg);
            sel_col             = COORD_W'(s2_col_reg);
            sel_last            = 1'b1;
            s2_mask_next.corner = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_mask_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s2_mask_reg <= s1_mask_reg;
            else if (out_load)
                s2_mask_reg <= s2_mask_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (energy_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_e1_reg  <= e1;
            s2_e2_reg  <= e2;
            s2_e3_reg  <= e3;
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
        if (out_load)
        begin
            out_energy_reg <= sel_energy;
            out_row_reg    <= sel_row;
            out_col_reg    <= sel_col;
            out_last_reg   <= sel_last;
        end
    end

    // ---------------- ports ----------------
    assign pixel_in.ready           = in_ready;
    assign energy_out.valid         = out_valid_reg;
    assign energy_out.energy        = out_energy_reg;
    assign energy_out.out_row       = out_row_reg;
    assign energy_out.out_col       = out_col_reg;
    assign energy_out.last_of_image = out_last_reg;

endmodule

[rtl/dgpe_line_store.sv]
// Two line memories (row above, row two above) with one write and one registered read port each.
module dgpe_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output dgpe_pkg::pixel_t      rd_above,
    output dgpe_pkg::pixel_t      rd_two,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  dgpe_pkg::pixel_t      wr_above,
    input  dgpe_pkg::pixel_t      wr_two
);
    import dgpe_pkg::*;

    pixel_t above_mem [DEPTH];
    pixel_t two_mem   [DEPTH];
    pixel_t rd_above_reg;
    pixel_t rd_two_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            above_mem[wr_addr] <= wr_above;
        end
        if (rd_en)
        begin
            rd_above_reg <= above_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            two_mem[wr_addr] <= wr_two;
        end
        if (rd_en)
        begin
            rd_two_reg <= two_mem[rd_addr];
        end
    end

    assign rd_above = rd_above_reg;
    assign rd_two   = rd_two_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the dual-gradient pixel energy unit.
`timescale 1ns / 1ps

module testbench;
    import dgpe_pkg::*;

    // Largest image side; matches the parameters given to the instance below
    localparam int SIDE_MAX     = 1024;
    // Long receiver hold-off, used to back the block up into its input
    localparam int LONG_HOLD    = 400;
    // Watchdog: cycles with no beat on either channel before giving up
    localparam int STALL_LIMIT  = 3000;
    // Energies leave through the unit's pipeline registers after their releasing beat; a
    // pixel on row 0 releases nothing, so after the queue empties the stimulus still waits
    // before any size register is touched
    localparam int SETTLE       = 8;
    localparam int RANDOM_ITEMS = 240;

    // One energy beat as seen on the result channel
    typedef struct packed {
        energy_t energy;
        coord_t  row;
        coord_t  col;
        logic    last;
    } energy_beat_t;

    // Receiver ready patterns
    typedef enum int {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_TOGGLE
    } rx_mode_t;

    // Energy predictor and scoreboard: tracks the raster position, the two
    // previous rows and the small pixel window, and queues the energies that
    // each accepted pixel releases.
    class energy_scoreboard;
        cfg_data_t    width_raw;
        cfg_data_t    height_raw;
        pixel_t       line_above [SIDE_MAX];
        pixel_t       line_two_above [SIDE_MAX];
        // 0: previous row at c-1, 1: current row at c-1, 2: current row at c-2
        pixel_t       win [3];
        int           next_col;
        int           next_row;
        energy_beat_t expected_q [$];
        int           mismatches;

        function new();
            width_raw  = cfg_data_t'(CFG_RESET_SIZE);
            height_raw = cfg_data_t'(CFG_RESET_SIZE);
            foreach (line_above[i])
            begin
                line_above[i]     = '0;
                line_two_above[i] = '0;
            end
            win        = '{default: '0};
            next_col   = 0;
            next_row   = 0;
            mismatches = 0;
        endfunction

        function int saturate_side(cfg_data_t v);
            if (v < 2)
                return 2;
            if (v > SIDE_MAX)
                return SIDE_MAX;
            return int'(v);
        endfunction

        function int eff_width();
            return saturate_side(width_raw);
        endfunction

        function int eff_height();
            return saturate_side(height_raw);
        endfunction

        function void write_reg(cfg_index_t idx, cfg_data_t v);
            case (idx)
                REG_IMAGE_WIDTH:  width_raw  = v;
                REG_IMAGE_HEIGHT: height_raw = v;
                default:          ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Sum of squared channel differences between two pixels
        function int color_gradient(pixel_t a, pixel_t b);
            int total;
            int d;
            total = 0;
            for (int k = 0; k < 3; k++)
            begin
                d     = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
                total += d * d;
            end
            return total;
        endfunction

        function void push_energy(int e, int r, int c, logic last);
            energy_beat_t b;
            b.energy = energy_t'(e);
            b.row    = coord_t'(r);
            b.col    = coord_t'(c);
            b.last   = last;
            expected_q.insert(expected_q.size(), b);
        endfunction

        function void note_pixel(pixel_t p);
            int     w;
            int     h;
            int     c;
            int     r;
            pixel_t above;
            pixel_t two_above;
            pixel_t ha;
            pixel_t hb;
            pixel_t va;
            w = eff_width();
            h = eff_height();
            // size shrank under the current position: a new image starts
            if (next_col >= w || next_row >= h)
            begin
                next_col = 0;
                next_row = 0;
            end
            c         = next_col;
            r         = next_row;
            above     = line_above[c];
            two_above = line_two_above[c];

            // pixel one row up is now complete
            if (r >= 1)
            begin
                ha = (c == 0) ? above : win[0];
                hb = (c == w - 1) ? above : line_above[c + 1];
                va = (r == 1) ? above : two_above;
                push_energy(color_gradient(ha, hb) + color_gradient(va, p), r - 1, c, 1'b0);
            end
            // bottom row: its own energies follow, one column behind
            if (r == h - 1)
            begin
                if (c >= 1)
                begin
                    ha = (c == 1) ? win[1] : win[2];
                    push_energy(color_gradient(ha, p) + color_gradient(win[1], win[0]),
                                r, c - 1, 1'b0);
                end
                if (c == w - 1)
                    push_energy(color_gradient(p, win[1]) + color_gradient(p, above),
                                r, c, 1'b1);
            end

            win[2]            = win[1];
            win[1]            = p;
            win[0]            = above;
            line_two_above[c] = above;
            line_above[c]     = p;

            next_col = c + 1;
            if (next_col >= w)
            begin
                next_col = 0;
                next_row = r + 1;
                if (next_row >= h)
                    next_row = 0;
            end
        endfunction

        function void check_energy(energy_beat_t got);
            energy_beat_t want;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected energy beat: %0d (%0d,%0d) last %0b",
                             $realtime, got.energy, got.row, got.col, got.last);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.energy !== want.energy || got.row !== want.row ||
                got.col !== want.col || got.last !== want.last)
            begin
                if (mismatches < 10)
                    $display("%0t: mismatch exp %0d (%0d,%0d) %0b got %0d (%0d,%0d) %0b",
                             $realtime, want.energy, want.row, want.col, want.last,
                             got.energy, got.row, got.col, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    dgpe_pixel_if  pix ();
    dgpe_energy_if nrg ();

    dual_gradient_pixel_energy_unit #(
        .MAX_WIDTH  (SIDE_MAX),
        .MAX_HEIGHT (SIDE_MAX)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel_in   (pix.sink),
        .energy_out (nrg.source)
    );

    energy_scoreboard sb = new();

    // Sender burst state
    int burst_left    = 0;
    bit steady        = 1'b0;
    // Long receiver hold-offs asked for by the stimulus, and those served
    int hold_requests = 0;
    int holds_served  = 0;
    int random_items  = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one pixel beat; bursts of random length with random gaps between
    // them, unless the current image runs in steady mode (no gaps at all).
    task automatic send_pixel(pixel_t p);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pix.valid     <= 1'b1;
        pix.pixel_rgb <= p;
        do
            @(posedge clk);
        while (!pix.ready);
        sb.note_pixel(p);
    endtask

    // Stop offering, wait for every queued energy, then let the pipe settle.
    // The loop always waits on the clock before it checks, so valid is never lowered and raised
    // within the same step.
    task automatic drain(int settle);
        pix.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Write both size registers, width first
    task automatic program_size(int w_raw, int h_raw);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= cfg_data_t'(w_raw);
        @(posedge clk);
        sb.write_reg(REG_IMAGE_WIDTH, cfg_data_t'(w_raw));
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= cfg_data_t'(h_raw);
        @(posedge clk);
        sb.write_reg(REG_IMAGE_HEIGHT, cfg_data_t'(h_raw));
        cfg_we    <= 1'b0;
    endtask

    // Random pixel, with saturated channels now and then
    function automatic pixel_t random_pixel();
        pixel_t p;
        p = pixel_t'($urandom);
        if ($urandom_range(0, 3) == 0)
            for (int k = 0; k < 3; k++)
                if ($urandom_range(0, 1) == 1)
                    p[8*k +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    // Mostly small sides; sometimes below the minimum so saturation kicks in
    function automatic int pick_side();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1);
        return $urandom_range(2, 12);
    endfunction

    // Receiver: checks every accepted energy beat and drives ready from a
    // randomly picked pattern, or holds off for a long stretch when the
    // stimulus asks for it.
    initial
    begin
        int       hold_left;
        int       mode_left;
        rx_mode_t mode;
        logic     rdy;
        energy_beat_t got;
        hold_left = 0;
        mode_left = 0;
        mode      = RX_OPEN;
        nrg.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (nrg.valid && nrg.ready)
                begin
                    got.energy = nrg.energy;
                    got.row    = nrg.out_row;
                    got.col    = nrg.out_col;
                    got.last   = nrg.last_of_image;
                    sb.check_energy(got);
                end
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:  rdy = 1'b1;
                    RX_LIGHT: rdy = ($urandom_range(0, 3) != 0);
                    RX_HEAVY: rdy = ($urandom_range(0, 3) == 0);
                    default:  rdy = ~nrg.ready;
                endcase
                if (hold_left > 0)
                begin
                    hold_left--;
                    rdy = 1'b0;
                end
                else if (holds_served < hold_requests)
                begin
                    holds_served++;
                    hold_left = LONG_HOLD;
                    rdy       = 1'b0;
                end
                nrg.ready <= rdy;
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pix.valid && pix.ready) || (nrg.valid && nrg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles, %0d energies outstanding",
                 $realtime, STALL_LIMIT, sb.pending());
        $display("FAIL dual_gradient_pixel_energy_unit");
        $finish;
    end

    // Main stimulus
    initial
    begin
        int     w_raw;
        int     h_raw;
        int     n;
        int     pause_at;
        bit     first;
        // two 2x2 images back to back: full swings, then primaries and white
        pixel_t tiny_img [8];
        // 3x3 image whose center pixel reaches the largest possible energy
        pixel_t peak_img [9];

        tiny_img = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
                     24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF};
        peak_img = '{24'h123456, 24'h000000, 24'hABCDEF,
                     24'h000000, 24'h808080, 24'hFFFFFF,
                     24'h555555, 24'hFFFFFF, 24'h0F0F0F};

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_IMAGE_WIDTH;
        cfg_data      <= '0;
        pix.valid     <= 1'b0;
        pix.pixel_rgb <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- directed ---------------------------------------------------
        // Sides written below the minimum saturate to 2; the second image
        // starts right after the counters wrap at the end of the first.
        program_size(0, 1);
        foreach (tiny_img[i])
            send_pixel(tiny_img[i]);
        drain(SETTLE);

        program_size(3, 3);
        foreach (peak_img[i])
            send_pixel(peak_img[i]);
        drain(SETTLE);

        // Width cut below the current column: counters restart on a new image
        program_size(5, 4);
        for (int i = 0; i < 7; i++)
            send_pixel(random_pixel());
        drain(SETTLE);
        program_size(2, 4);
        for (int i = 0; i < 7; i++)
            send_pixel(random_pixel());
        drain(SETTLE);
        // Height cut below the current row: same restart on the row counter
        program_size(2, 2);
        for (int i = 0; i < 4; i++)
            send_pixel(random_pixel());
        drain(SETTLE);

        // --- sides above the maximum saturate to it ----------------------
        // Only the start of each image is sent; the next size restarts it.
        program_size(2047, 0);
        for (int i = 0; i < 24; i++)
            send_pixel(random_pixel());
        drain(SETTLE);
        program_size(1, 1500);
        for (int i = 0; i < 40; i++)
            send_pixel(random_pixel());
        drain(SETTLE);

        // --- random images -----------------------------------------------
        // Mostly whole images (one or two per setting), some cut short.
        // After a cut image the next size is picked so the counters
        // restart; when that cannot happen the size stays as it is.
        // The first image runs without gaps under a long receiver hold-off,
        // so the block fills and drops its input ready.
        w_raw = 12;
        h_raw = 10;
        first = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            drain(SETTLE);
            if (!first)
            begin
                if (sb.next_col != 0 || sb.next_row != 0)
                begin
                    if (sb.next_col >= 2)
                    begin
                        w_raw = $urandom_range(2, sb.next_col);
                        h_raw = pick_side();
                    end
                    else if (sb.next_row >= 2)
                    begin
                        h_raw = $urandom_range(2, sb.next_row);
                        w_raw = pick_side();
                    end
                end
                else
                begin
                    w_raw = pick_side();
                    h_raw = pick_side();
                end
            end
            program_size(w_raw, h_raw);
            if (first)
                hold_requests++;
            steady = first || ($urandom_range(0, 3) == 0);
            n      = sb.eff_width() * sb.eff_height();
            if (!first && $urandom_range(0, 4) == 0)
                n = $urandom_range(1, n - 1);
            else
                n = n * $urandom_range(1, 2);
            // now and then the sender stops mid-image until all is out
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    drain(1);
                send_pixel(random_pixel());
                random_items++;
            end
            first = 1'b0;
        end

        drain(SETTLE);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS dual_gradient_pixel_energy_unit");
        else
            $display("FAIL dual_gradient_pixel_energy_unit");
        $finish;
    end

endmodule
